@@ hw/rtl/fault_history_ring_log_macros.svh @@
// ---------------------------------------------------------------------------
// Fault history ring log: assertion macros
// Implication checks on the rising clock edge, off while reset is active.
// ---------------------------------------------------------------------------
`ifndef FAULT_HISTORY_RING_LOG_MACROS_SVH
`define FAULT_HISTORY_RING_LOG_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define FHRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FHRL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define FHRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define FHRL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/fhrl_pkg.sv @@
// ---------------------------------------------------------------------------
// Fault history ring log: package
// Ring size, counter widths and request/response types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fhrl_pkg;

	// Ring size, 1 to 255 entries.
	localparam int unsigned RING_ENTRIES = 16;
	localparam int unsigned SLOT_W       = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
	localparam int unsigned COUNT_W      = 8;
	localparam int unsigned POS_W        = COUNT_W + 1;

	localparam logic [COUNT_W-1:0] TOTAL_CAP  = COUNT_W'(255);
	localparam logic [COUNT_W-1:0] RING_COUNT = COUNT_W'(RING_ENTRIES);
	localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(RING_ENTRIES - 1);

	typedef enum logic {
		ACT_APPEND = 1'b0,
		ACT_QUERY  = 1'b1
	} action_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  fault_code;
		logic [7:0]  fault_detail;
		logic [31:0] uptime_stamp;
		logic [7:0]  newest_rank;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [31:0] got_uptime;
		logic [7:0]  got_code;
		logic [7:0]  got_detail;
	} rsp_t;

	typedef struct packed {
		logic [31:0] uptime;
		logic [7:0]  code;
		logic [7:0]  detail;
	} entry_t;

endpackage

@@ hw/rtl/fault_history_ring_log.sv @@
// ---------------------------------------------------------------------------
// Fault history ring log
// Records fault entries in a fixed ring and answers k-th-newest lookups.
// ---------------------------------------------------------------------------
//
//  channel | signals                  | moves
//  --------+--------------------------+------------------------------------
//  req     | req_valid, req_stall, req | append or query request (in)
//  rsp     | rsp_valid, rsp_stall, rsp | one response per query (out)
//
// One request per cycle is accepted while req_stall is low. A request lands
// in the s1 register; from there it either commits an append (store, head,
// count) or, once the response register can take it, loads the query answer
// into the response register. Reset clears the valid flags, head and count;
// the ring storage is not cleared since the rank guard never reads an
// unwritten slot. A stalled response blocks s1 only if s1 holds a query.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fault_history_ring_log_macros.svh"

module fault_history_ring_log (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fhrl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fhrl_pkg::rsp_t rsp
);

	// Stage 1: accepted request
	logic           valid_s1;
	fhrl_pkg::req_t req_s1;

	// Ring state
	fhrl_pkg::entry_t                  entry_q [fhrl_pkg::RING_ENTRIES];
	logic [fhrl_pkg::SLOT_W-1:0]       head_q;
	logic [fhrl_pkg::COUNT_W-1:0]      total_q;

	// Response register
	logic           rsp_valid_q;
	fhrl_pkg::rsp_t rsp_q;

	logic                          is_append;
	logic                          s1_adv;
	logic                          append_fire;
	logic                          query_fire;
	logic [fhrl_pkg::COUNT_W-1:0]  avail;
	logic                          found;
	logic [fhrl_pkg::POS_W-1:0]    pos_raw;
	logic [fhrl_pkg::POS_W-1:0]    pos_wrap;
	logic [fhrl_pkg::SLOT_W-1:0]   rd_slot;
	fhrl_pkg::entry_t              rd_entry;
	fhrl_pkg::rsp_t                rsp_next;

	// Flow control: an append always retires; a query waits for the
	// response register to be free or drained this cycle.
	assign is_append   = (req_s1.action == fhrl_pkg::ACT_APPEND);
	assign s1_adv      = is_append || !rsp_valid_q || !rsp_stall;
	assign req_stall   = valid_s1 && !s1_adv;
	assign append_fire = valid_s1 && is_append;
	assign query_fire  = valid_s1 && !is_append && s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// Available ranks: min(total, ring size)
	always_comb begin
		avail = (total_q < fhrl_pkg::RING_COUNT) ? total_q : fhrl_pkg::RING_COUNT;
		found = (req_s1.newest_rank < avail);
	end

	// Slot of the k-th newest entry: head - 1 - k, wrapped once.
	// The sum stays non-negative whenever found is set.
	always_comb begin
		pos_raw  = fhrl_pkg::POS_W'(head_q) + fhrl_pkg::POS_W'(fhrl_pkg::RING_ENTRIES - 1)
			- fhrl_pkg::POS_W'(req_s1.newest_rank);
		pos_wrap = (pos_raw >= fhrl_pkg::POS_W'(fhrl_pkg::RING_ENTRIES))
			? pos_raw - fhrl_pkg::POS_W'(fhrl_pkg::RING_ENTRIES) : pos_raw;
		rd_slot  = pos_wrap[fhrl_pkg::SLOT_W-1:0];
		rd_entry = entry_q[rd_slot];
	end

	always_comb begin
		rsp_next.found      = found;
		rsp_next.got_uptime = found ? rd_entry.uptime : '0;
		rsp_next.got_code   = found ? rd_entry.code   : '0;
		rsp_next.got_detail = found ? rd_entry.detail : '0;
	end

	// Ring storage, written at the head on append
	always_ff @(posedge clk) begin
		if (append_fire) begin
			entry_q[head_q] <= '{uptime: req_s1.uptime_stamp,
				code: req_s1.fault_code, detail: req_s1.fault_detail};
		end
	end

	// Head wraps at the last slot; count saturates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			total_q <= '0;
		end else if (append_fire) begin
			head_q  <= (head_q == fhrl_pkg::LAST_SLOT) ? '0 : head_q + 1'b1;
			if (total_q != fhrl_pkg::TOTAL_CAP) begin
				total_q <= total_q + 1'b1;
			end
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (query_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (query_fire) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	`FHRL_ASSERT_IMP(a_found_needs_entry, clk, arst_n,
		rsp_valid && rsp.found, total_q != '0, "found response with empty log")
	`FHRL_ASSERT_IMP(a_miss_zero_payload, clk, arst_n,
		rsp_valid && !rsp.found,
		(rsp.got_uptime == '0) && (rsp.got_code == '0) && (rsp.got_detail == '0),
		"miss response carries nonzero payload")
	`FHRL_ASSERT_NXT(a_count_saturates, clk, arst_n,
		append_fire,
		($past(total_q) == fhrl_pkg::TOTAL_CAP) ? (total_q == fhrl_pkg::TOTAL_CAP)
			: (total_q == $past(total_q) + 1'b1),
		"append count did not step or saturate")
	`FHRL_ASSERT_IMP(a_stall_only_when_busy, clk, arst_n,
		req_stall, valid_s1 && !is_append && rsp_valid_q,
		"request stalled without a blocked query")

endmodule
